[hdl/mkh_pkg.sv]
package mkh_pkg;

  // MurmurHash2 mixing constants
  localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;
  localparam logic [31:0] HASH_SEED   = 32'h0000_0000;

  // Field widths and packing of the input stream
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 32;

  // How the current item is mixed
  typedef enum logic [1:0] {
    KIND_BLOCK,
    KIND_TAIL,
    KIND_EMPTY
  } kind_t;

  // Datapath operations, one per cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_K1,
    OP_K2,
    OP_HMIX,
    OP_TAIL,
    OP_FIN,
    OP_EMIT
  } dp_op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_HMIX,
    ST_TAIL,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;      // classification of the item at the input
    logic  out_busy;  // output register holds a result that is not taken
  } dp_stat_t;

endpackage

[hdl/mkh_dp.sv]
module mkh_dp
  import mkh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [WORD_W-1:0]     key_word,
  input  logic [COUNT_W-1:0]    byte_count,
  input  logic                  last,
  input  logic [LEN_W-1:0]      key_length,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           hash_value
);

  logic [31:0] h_r, h_nxt;
  logic [31:0] k_r, k_nxt;
  logic [31:0] w_r, w_nxt;
  logic        inside_r, inside_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic [31:0] masked_word;
  logic [31:0] mul_a;
  logic [31:0] prod;
  kind_t       kind;

  // Classify the item at the input
  always_comb begin
    if (!last) begin
      kind = KIND_BLOCK;
    end else if (byte_count == 3'd0) begin
      kind = KIND_EMPTY;
    end else if (byte_count >= 3'd4) begin
      kind = KIND_BLOCK;
    end else begin
      kind = KIND_TAIL;
    end
  end

  // Keep only the valid bytes of a tail word
  always_comb begin
    unique case (byte_count)
      3'd1:    masked_word = {24'h0, key_word[7:0]};
      3'd2:    masked_word = {16'h0, key_word[15:0]};
      3'd3:    masked_word = {8'h0, key_word[23:0]};
      default: masked_word = key_word;
    endcase
    if (!last) begin
      masked_word = key_word;
    end
  end

  // Shared constant multiplier, operand chosen by the operation
  always_comb begin
    unique case (cmd.op)
      OP_K1:   mul_a = w_r;
      OP_K2:   mul_a = k_r ^ (k_r >> MIX_SHIFT);
      OP_TAIL: mul_a = h_r ^ w_r;
      OP_FIN:  mul_a = h_r ^ (h_r >> FIN_SHIFT_A);
      default: mul_a = h_r;
    endcase
  end

  assign prod = mul_a * MIX_MUL;

  // Next state of the datapath registers
  always_comb begin
    h_nxt         = h_r;
    k_nxt         = k_r;
    w_nxt         = w_r;
    inside_nxt    = inside_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (cmd.op)
      OP_LOAD: begin
        h_nxt      = inside_r ? h_r : (HASH_SEED ^ key_length);
        w_nxt      = masked_word;
        inside_nxt = 1'b1;
      end
      OP_K1, OP_K2: k_nxt = prod;
      OP_HMIX:      h_nxt = prod ^ k_r;
      OP_TAIL, OP_FIN: h_nxt = prod;
      OP_EMIT: begin
        out_data_nxt  = h_r ^ (h_r >> FIN_SHIFT_B);
        out_valid_nxt = 1'b1;
        inside_nxt    = 1'b0;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      inside_r    <= inside_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    h_r        <= h_nxt;
    k_r        <= k_nxt;
    w_r        <= w_nxt;
    out_data_r <= out_data_nxt;
  end

  assign stat.kind     = kind;
  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign hash_value    = out_data_r;

endmodule

[hdl/mkh_ctrl.sv]
module mkh_ctrl
  import mkh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   fin_r, fin_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // Sequence the datapath operations for one item
  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op  = OP_LOAD;
          fin_nxt = in_last;
          unique case (stat.kind)
            KIND_BLOCK: state_nxt = ST_K1;
            KIND_TAIL:  state_nxt = ST_TAIL;
            default:    state_nxt = ST_FIN;
          endcase
        end
      end
      ST_K1: begin
        cmd.op    = OP_K1;
        state_nxt = ST_K2;
      end
      ST_K2: begin
        cmd.op    = OP_K2;
        state_nxt = ST_HMIX;
      end
      ST_HMIX: begin
        cmd.op    = OP_HMIX;
        state_nxt = fin_r ? ST_FIN : ST_IDLE;
      end
      ST_TAIL: begin
        cmd.op    = OP_TAIL;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.op    = OP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[hdl/murmur2_key_hash.sv]
// Streaming MurmurHash2 (32-bit, seed 0), one shared constant multiplier.
// A non-last item is accepted, then mixed by three multiplies before the next is taken.
// Last item: block mix, tail mix or nothing, then the final mix and the result emit.
// Result sits in an output register; the next key is accepted while it waits.
// Reset (rst_n low, synchronous) clears the sequencer, the in-key flag and output valid.
module murmur2_key_hash
  import mkh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // tdata: key_word[31:0], byte_count[34:32], key_length[66:35], zero[71:67]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: hash_value[31:0]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mkh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mkh_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_word   (in_tdata[31:0]),
    .byte_count (in_tdata[34:32]),
    .last       (in_tlast),
    .key_length (in_tdata[66:35]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .hash_value (out_tdata)
  );

endmodule
